// File: rtl/core/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life grid generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int SIDE_LEN_DEF = 64;

  localparam int CMD_W = 2;
  localparam int ROW_W = 6;
  localparam int COL_W = 6;

  // neighbor count width, eight neighbors at most
  localparam int NBR_W = 4;
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_TOGGLE = 2'd0,
    CMD_STEP   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

// File: rtl/core/lgs_row_cell.sv
// ----------------------------------------------------------------------------
// lgs_row_cell
// One row of the grid; passes its row to the next cell on each shift.
// ----------------------------------------------------------------------------
module lgs_row_cell import lgs_pkg::*; #(
  parameter int WIDTH = SIDE_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      q <= '0;
    end else if (ctl.shift) begin
      q <= d;
    end
  end

endmodule

// File: rtl/core/lgs_rule_unit.sv
// ----------------------------------------------------------------------------
// lgs_rule_unit
// B3/S23 rule for one row, from the rows above and below; edges are dead.
// ----------------------------------------------------------------------------
module lgs_rule_unit import lgs_pkg::*; #(
  parameter int WIDTH = SIDE_LEN_DEF
) (
  input  logic [WIDTH-1:0] above,
  input  logic [WIDTH-1:0] cur,
  input  logic [WIDTH-1:0] below,
  output logic [WIDTH-1:0] next_row
);

  logic [WIDTH+1:0] a_p;
  logic [WIDTH+1:0] c_p;
  logic [WIDTH+1:0] b_p;

  assign a_p = {1'b0, above, 1'b0};
  assign c_p = {1'b0, cur, 1'b0};
  assign b_p = {1'b0, below, 1'b0};

  for (genvar j = 0; j < WIDTH; j++) begin : g_lane
    logic [NBR_W-1:0] cnt;
    assign cnt = NBR_W'(a_p[j]) + NBR_W'(a_p[j+1]) + NBR_W'(a_p[j+2]) +
                 NBR_W'(c_p[j]) + NBR_W'(c_p[j+2]) +
                 NBR_W'(b_p[j]) + NBR_W'(b_p[j+1]) + NBR_W'(b_p[j+2]);
    assign next_row[j] = (cnt == BIRTH_COUNT) || (c_p[j+1] && (cnt == SURVIVE_COUNT));
  end

endmodule

// File: rtl/core/life_grid_generation_step.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Square life grid, rule B3/S23, held as a ring of row cells.
//
//   port group   dir   tdata fields (lsb first)
//   s_*          in    command[1:0], row[7:2], col[13:8], zero[15:14]
//   m_*          out   cell_alive[0], zero[7:1]
//
// Every item rotates the whole ring once, one row per cycle. The result is
// loaded into the output register when the sweep ends and the output is free,
// and no new item is taken before that. The row at the ring tail is updated
// and fed back to the head. Reset clears all rows at once. A result still
// waiting at the end of a sweep holds the block, and so the next item, until
// it is taken.
// ----------------------------------------------------------------------------
module life_grid_generation_step import lgs_pkg::*; #(
  parameter int SIDE_LEN = SIDE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // command[1:0], row[7:2], col[13:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // cell_alive[0]
);

  localparam int RB = $clog2(SIDE_LEN);
  localparam int CW = (RB > ROW_W) ? RB : ROW_W;
  localparam logic [CW:0]   SIZE_V = (CW+1)'(SIDE_LEN);
  localparam logic [RB-1:0] LAST_IDX = RB'(SIDE_LEN - 1);

  state_t state;
  state_t state_next;

  cmd_t             cmd_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             on_grid_q;
  logic [RB-1:0]    idx;
  logic             res_q;
  logic             cell_alive;

  logic [SIDE_LEN-1:0] rows [SIDE_LEN];
  logic [SIDE_LEN-1:0] below_old;
  logic [SIDE_LEN-1:0] fb;
  logic [SIDE_LEN-1:0] rule_row;
  logic [SIDE_LEN-1:0] above_g;
  logic [SIDE_LEN-1:0] below_g;
  logic [SIDE_LEN-1:0] tail;

  logic          accept;
  logic          shift_en;
  logic          load_out;
  logic          is_target;
  logic          res_now;
  logic [CW-1:0] col_ext;
  logic [RB-1:0] col_idx;
  logic          in_on_grid;
  cell_ctl_t     ctl;

  assign accept     = s_tvalid && s_tready;
  assign in_on_grid = ((CW+1)'(s_tdata[7:2]) < SIZE_V) && ((CW+1)'(s_tdata[13:8]) < SIZE_V);
  assign tail       = rows[SIDE_LEN-1];
  assign col_ext    = CW'(col_q);
  assign col_idx    = col_ext[RB-1:0];
  assign is_target  = on_grid_q && (CW'(idx) == CW'(row_q));

  // ring of row cells
  assign ctl.shift = shift_en;
  assign ctl.clear = 1'b0;

  for (genvar i = 0; i < SIDE_LEN; i++) begin : g_row
    lgs_row_cell #(.WIDTH(SIDE_LEN)) u_cell (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .d   ((i == 0) ? fb : rows[(i == 0) ? 0 : i-1]),
      .q   (rows[i])
    );
  end

  assign above_g = (idx != '0) ? rows[SIDE_LEN-2] : '0;
  assign below_g = (idx != LAST_IDX) ? below_old : '0;

  lgs_rule_unit #(.WIDTH(SIDE_LEN)) u_rule (
    .above    (above_g),
    .cur      (tail),
    .below    (below_g),
    .next_row (rule_row)
  );

  always_comb begin
    case (cmd_q)
      CMD_TOGGLE: fb = is_target ? (tail ^ (SIDE_LEN'(1) << col_idx)) : tail;
      CMD_STEP:   fb = rule_row;
      CMD_CLEAR:  fb = '0;
      CMD_READ:   fb = tail;
      default:    fb = tail;
    endcase
  end

  assign res_now = is_target ? fb[col_idx] : res_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q     <= cmd_t'(s_tdata[1:0]);
      row_q     <= s_tdata[7:2];
      col_q     <= s_tdata[13:8];
      on_grid_q <= in_on_grid;
      res_q     <= 1'b0;
    end else if (shift_en) begin
      res_q <= res_now;
    end
    if (shift_en) begin
      below_old <= tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      idx <= LAST_IDX;
    end else if (shift_en && idx != '0) begin
      idx <= idx - RB'(1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (idx == '0) state_next = (m_tvalid && !m_tready) ? ST_HOLD : ST_IDLE;
      end
      ST_HOLD: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    shift_en = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_SWEEP: begin
        shift_en = 1'b1;
        load_out = (idx == '0) && (!m_tvalid || m_tready);
      end
      ST_HOLD: begin
        load_out = m_tready;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load_out) begin
      cell_alive <= (state == ST_SWEEP) ? res_now : res_q;
    end
  end

  assign m_tdata = {7'b0, cell_alive};

  a_accept_sweep: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SWEEP && idx == LAST_IDX))
    else $error("accepted item did not start a sweep");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && idx != '0) |=> (idx == $past(idx) - RB'(1)))
    else $error("sweep row counter skipped");

  a_off_grid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && !on_grid_q) |-> !res_q)
    else $error("off-grid result not zero");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> m_tvalid)
    else $error("holding a result with output empty");

endmodule

// File: tb/life_grid_generation_step_tb.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step_tb
// Self-checking bench for the life grid block. A shadow copy of the grid is
// kept in a small class. It applies toggle, step, clear and read to that copy
// and queues the addressed cell's value for each accepted item. Results
// coming off the master side are compared in order. Stimulus starts with
// hand-built patterns at the corners and in the middle. Random items then
// mostly seed small windows, step them and read around them, with raw noise
// and clears mixed in. Both sides throttle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module life_grid_generation_step_tb;
  import lgs_pkg::*;

  localparam int GRID_N       = SIDE_LEN_DEF;
  localparam int RANDOM_ITEMS = 650;
  localparam int LIMIT_CYCLES = 600000;

  class grid_scoreboard;
    bit   cells [GRID_N][GRID_N];
    bit   alive_q [$];
    int   errors;

    function bit cell_at(int r, int c);
      if (r < 0 || c < 0 || r >= GRID_N || c >= GRID_N) return 1'b0;
      return cells[r][c];
    endfunction

    function void advance_generation();
      bit nxt [GRID_N][GRID_N];
      int n;
      for (int r = 0; r < GRID_N; r++) begin
        for (int c = 0; c < GRID_N; c++) begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if (dr != 0 || dc != 0) n += cell_at(r + dr, c + dc);
            end
          end
          if (cells[r][c]) nxt[r][c] = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
          else nxt[r][c] = (n == BIRTH_COUNT);
        end
      end
      cells = nxt;
    endfunction

    // accepted input item: update shadow grid, queue addressed cell
    function void note_command(cmd_t cmd, int row, int col);
      bit on_grid;
      on_grid = (row < GRID_N) && (col < GRID_N);
      case (cmd)
        CMD_TOGGLE: begin
          if (on_grid) cells[row][col] = ~cells[row][col];
        end
        CMD_STEP: advance_generation();
        CMD_CLEAR: begin
          for (int r = 0; r < GRID_N; r++)
            for (int c = 0; c < GRID_N; c++) cells[r][c] = 1'b0;
        end
        default: ;
      endcase
      alive_q.insert(alive_q.size(), on_grid ? cells[row][col] : 1'b0);
    endfunction

    function void check_result(logic [7:0] data);
      bit want;
      if (alive_q.size() == 0) begin
        $error("unexpected result, cell_alive actual %0b", data[0]);
        errors++;
        return;
      end
      want = alive_q.pop_front();
      if (data[0] !== want) begin
        $error("cell_alive mismatch: expected %0b, actual %0b", want, data[0]);
        errors++;
      end
    endfunction

    function int pending();
      return alive_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // command[1:0], row[7:2], col[13:8]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // cell_alive[0]

  grid_scoreboard sb = new;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int cycles        = 0;

  life_grid_generation_step uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(cmd_t cmd, logic [5:0] row, logic [5:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, col, row, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_command(cmd, row, col);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(CMD_READ, 6'd0, 6'd0);
    send_item(CMD_TOGGLE, 6'd0, 6'd0);
    send_item(CMD_TOGGLE, 6'd0, 6'd63);
    send_item(CMD_TOGGLE, 6'd63, 6'd0);
    send_item(CMD_TOGGLE, 6'd63, 6'd63);
    send_item(CMD_TOGGLE, 6'd63, 6'd63);
    send_item(CMD_TOGGLE, 6'd63, 6'd63);
    // lone corner cells die
    send_item(CMD_STEP, 6'd0, 6'd0);
    // blinker in the middle
    send_item(CMD_TOGGLE, 6'd31, 6'd30);
    send_item(CMD_TOGGLE, 6'd31, 6'd31);
    send_item(CMD_TOGGLE, 6'd31, 6'd32);
    send_item(CMD_STEP, 6'd30, 6'd31);
    send_item(CMD_READ, 6'd31, 6'd30);
    send_item(CMD_STEP, 6'd31, 6'd30);
    // still block against the far corner, no wrap to row/col 0
    send_item(CMD_TOGGLE, 6'd62, 6'd62);
    send_item(CMD_TOGGLE, 6'd62, 6'd63);
    send_item(CMD_TOGGLE, 6'd63, 6'd62);
    send_item(CMD_TOGGLE, 6'd63, 6'd63);
    send_item(CMD_STEP, 6'd63, 6'd63);
    send_item(CMD_READ, 6'd0, 6'd0);
    send_item(CMD_READ, 6'd62, 6'd62);
    send_item(CMD_CLEAR, 6'd31, 6'd31);
    send_item(CMD_READ, 6'd63, 6'd63);
  endtask

  function automatic int pick_origin();
    case ($urandom_range(3))
      0: return 0;
      1: return GRID_N - 8;
      default: return $urandom_range(GRID_N - 8);
    endcase
  endfunction

  task automatic run_random(int target);
    int kind;
    int r0;
    int c0;
    while (items_sent < target) begin
      kind = $urandom_range(19);
      if (kind < 14) begin
        // seed a small window, then evolve it and look around
        r0 = pick_origin();
        c0 = pick_origin();
        repeat ($urandom_range(6, 16))
          send_item(CMD_TOGGLE, 6'(r0 + $urandom_range(7)), 6'(c0 + $urandom_range(7)));
        repeat ($urandom_range(1, 6)) begin
          send_item(CMD_STEP, 6'(r0 + $urandom_range(7)), 6'(c0 + $urandom_range(7)));
          repeat ($urandom_range(0, 3))
            send_item(CMD_READ, 6'(r0 + $urandom_range(7)), 6'(c0 + $urandom_range(7)));
        end
      end else if (kind < 19) begin
        repeat ($urandom_range(1, 4))
          send_item(cmd_t'($urandom_range(3)), 6'($urandom_range(63)),
                    6'($urandom_range(63)));
      end else begin
        send_item(CMD_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 84;
    run_directed();
    run_random(items_sent + RANDOM_ITEMS / 3);

    // hold off until the block has answered everything
    drain();
    send_idle_pct = 84;
    recv_idle_pct = 19;
    run_random(items_sent + RANDOM_ITEMS / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(items_sent + RANDOM_ITEMS / 3);

    drain();
    repeat (GRID_N + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
